/* sv/btlpm_pkg.sv */
// Shared types and constants for the binary trie route lookup block.
// Used by binary_trie_longest_prefix_match, its checker and its testbench; depends on nothing.
package btlpm_pkg;

  localparam int NodeCount = 4096;
  localparam int NodeIdxW  = $clog2(NodeCount);
  localparam int UsedW     = NodeIdxW + 1;
  localparam int AddrBits  = 32;
  localparam int PosW      = $clog2(AddrBits);
  localparam int LevelW    = PosW + 1;
  localparam int PortW     = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_STEP = 2'b10
  } state_e;

  // One trie node as kept in the node memory.
  typedef struct packed {
    logic                has_route;
    logic [NodeIdxW-1:0] left;
    logic [NodeIdxW-1:0] right;
  } node_t;

  // Route data as kept in the route memory.
  typedef struct packed {
    logic [AddrBits-1:0] hop;
    logic [PortW-1:0]    port;
  } route_t;

endpackage

/* sv/btlpm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module btlpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/binary_trie_longest_prefix_match.sv */
// Longest-prefix-match route table kept as a one-bit-per-level binary trie.
// Depends on btlpm_pkg and btlpm_ram (node memory and route memory).
//
// A request is taken when start_i is high and busy_o is low. Insert (opcode 0)
// walks the prefix from the top bit, descending on each set mask bit and taking
// fresh nodes from a 4096-node pool; it stores next hop and port at the last
// node, or reports status 1 and stores no route when the pool runs out. Lookup
// (opcode 1) walks the destination and returns the route of the deepest node on
// its path that holds one, including /32 routes. Each request yields exactly one
// result, shown for one cycle with done_o high; the receiver cannot stall, so
// the result must be captured in that cycle. The walk handles one trie level per
// clock. A lookup ends at the last level or at a missing child; an insert
// steps through all 33 levels, clear mask bits included, unless the pool runs
// out first. The result appears in the cycle busy_o drops, and the next start may
// be issued in that cycle. Node 0 reads as empty after reset without any
// clearing pass.
module binary_trie_longest_prefix_match (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  output logic                                done_o,
  input  logic                                opcode_i,
  input  logic [btlpm_pkg::AddrBits-1:0]      address_i,
  input  logic [btlpm_pkg::AddrBits-1:0]      prefix_mask_i,
  input  logic [btlpm_pkg::AddrBits-1:0]      route_next_hop_in_i,
  input  logic [btlpm_pkg::PortW-1:0]         route_port_in_i,
  output logic                                found_o,
  output logic [btlpm_pkg::AddrBits-1:0]      next_hop_o,
  output logic [btlpm_pkg::PortW-1:0]         out_port_o,
  output logic                                status_o
);

  localparam int NodeW  = $bits(btlpm_pkg::node_t);
  localparam int RouteW = $bits(btlpm_pkg::route_t);

  btlpm_pkg::state_e state_q, state_d;
  logic [btlpm_pkg::LevelW-1:0]   lvl_q, lvl_d;
  logic [btlpm_pkg::NodeIdxW-1:0] cur_q, cur_d;
  logic [btlpm_pkg::UsedW-1:0]    used_q, used_d;
  logic                           use_mem_q, use_mem_d;
  logic                           root_vld_q;
  logic                           done_q, done_d;
  btlpm_pkg::node_t               ent_q, ent_d, ent_cur, mem_ent;

  // Request payload
  btlpm_pkg::op_e                 op_q;
  logic [btlpm_pkg::AddrBits-1:0] addr_q, mask_q, hop_in_q;
  logic [btlpm_pkg::PortW-1:0]    port_in_q;

  // Result registers
  logic                           found_q, found_d;
  logic [btlpm_pkg::AddrBits-1:0] hop_q, hop_d;
  logic [btlpm_pkg::PortW-1:0]    port_q, port_d;
  btlpm_pkg::status_e             status_q, status_d;

  // Memory ports
  logic                           node_we, node_re, route_we, route_re;
  logic [btlpm_pkg::NodeIdxW-1:0] node_waddr, mem_raddr;
  btlpm_pkg::node_t               node_wdata;
  logic [NodeW-1:0]               node_rdata;
  btlpm_pkg::route_t              route_wdata;
  logic [RouteW-1:0]              route_rdata;
  btlpm_pkg::route_t              route_rd;

  logic                           accept;
  logic [btlpm_pkg::PosW-1:0]     pos;
  logic                           go_right, lvl_sel, last_lvl, pool_full;
  logic [btlpm_pkg::NodeIdxW-1:0] child;

  btlpm_ram #(
    .Width(NodeW),
    .Depth(btlpm_pkg::NodeCount)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(node_waddr),
    .wdata_i(node_wdata),
    .re_i   (node_re),
    .raddr_i(mem_raddr),
    .rdata_o(node_rdata)
  );

  btlpm_ram #(
    .Width(RouteW),
    .Depth(btlpm_pkg::NodeCount)
  ) u_route_ram (
    .clk_i  (clk_i),
    .we_i   (route_we),
    .waddr_i(cur_q),
    .wdata_i(route_wdata),
    .re_i   (route_re),
    .raddr_i(mem_raddr),
    .rdata_o(route_rdata)
  );

  assign accept   = start_i && (state_q == btlpm_pkg::S_IDLE);
  assign route_rd = btlpm_pkg::route_t'(route_rdata);

  // Root reads as empty until it is first written.
  assign mem_ent = ((cur_q == '0) && !root_vld_q) ? '0 : btlpm_pkg::node_t'(node_rdata);
  assign ent_cur = use_mem_q ? mem_ent : ent_q;

  assign pos       = btlpm_pkg::PosW'(btlpm_pkg::AddrBits - 1) - lvl_q[btlpm_pkg::PosW-1:0];
  assign go_right  = addr_q[pos];
  assign lvl_sel   = mask_q[pos];
  assign last_lvl  = (lvl_q == btlpm_pkg::LevelW'(btlpm_pkg::AddrBits));
  assign child     = go_right ? ent_cur.right : ent_cur.left;
  assign pool_full = (used_q == btlpm_pkg::UsedW'(btlpm_pkg::NodeCount));

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    cur_d       = cur_q;
    used_d      = used_q;
    use_mem_d   = 1'b0;
    ent_d       = ent_cur;
    done_d      = 1'b0;
    found_d     = found_q;
    hop_d       = hop_q;
    port_d      = port_q;
    status_d    = status_q;
    node_re     = 1'b0;
    route_re    = 1'b0;
    mem_raddr   = child;
    node_we     = 1'b0;
    node_waddr  = cur_q;
    node_wdata  = ent_cur;
    route_we    = 1'b0;
    route_wdata = '{hop: hop_in_q, port: port_in_q};

    unique case (state_q)
      btlpm_pkg::S_IDLE: begin
        if (start_i) begin
          state_d   = btlpm_pkg::S_STEP;
          lvl_d     = '0;
          cur_d     = '0;
          use_mem_d = 1'b1;
          mem_raddr = '0;
          node_re   = 1'b1;
          route_re  = 1'b1;
          found_d   = 1'b0;
          hop_d     = '0;
          port_d    = '0;
          status_d  = btlpm_pkg::STATUS_OK;
        end
      end
      btlpm_pkg::S_STEP: begin
        if (op_q == btlpm_pkg::OP_LOOKUP) begin
          if (ent_cur.has_route) begin
            found_d = 1'b1;
            hop_d   = route_rd.hop;
            port_d  = route_rd.port;
          end
          if (last_lvl || (child == '0)) begin
            state_d = btlpm_pkg::S_IDLE;
            done_d  = 1'b1;
          end else begin
            node_re   = 1'b1;
            route_re  = 1'b1;
            cur_d     = child;
            use_mem_d = 1'b1;
            lvl_d     = lvl_q + 1'b1;
          end
        end else begin
          priority if (last_lvl) begin
            // Store the route at the node where the walk ends.
            node_we              = 1'b1;
            node_wdata.has_route = 1'b1;
            route_we             = 1'b1;
            state_d              = btlpm_pkg::S_IDLE;
            done_d               = 1'b1;
          end else if (!lvl_sel) begin
            lvl_d = lvl_q + 1'b1;
          end else if (child != '0) begin
            node_re   = 1'b1;
            cur_d     = child;
            use_mem_d = 1'b1;
            lvl_d     = lvl_q + 1'b1;
          end else if (pool_full) begin
            // Write back the current node, which may be fresh and not yet stored.
            node_we  = 1'b1;
            status_d = btlpm_pkg::STATUS_FULL;
            state_d  = btlpm_pkg::S_IDLE;
            done_d   = 1'b1;
          end else begin
            // Link a fresh node; it stays in ent_q until written on departure.
            node_we = 1'b1;
            if (go_right) begin
              node_wdata.right = used_q[btlpm_pkg::NodeIdxW-1:0];
            end else begin
              node_wdata.left = used_q[btlpm_pkg::NodeIdxW-1:0];
            end
            cur_d  = used_q[btlpm_pkg::NodeIdxW-1:0];
            ent_d  = '0;
            used_d = used_q + 1'b1;
            lvl_d  = lvl_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = btlpm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= btlpm_pkg::S_IDLE;
      lvl_q      <= '0;
      cur_q      <= '0;
      used_q     <= btlpm_pkg::UsedW'(1);
      use_mem_q  <= 1'b0;
      root_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      cur_q     <= cur_d;
      used_q    <= used_d;
      use_mem_q <= use_mem_d;
      done_q    <= done_d;
      if (node_we && (node_waddr == '0)) begin
        root_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    found_q  <= found_d;
    hop_q    <= hop_d;
    port_q   <= port_d;
    status_q <= status_d;
    if (accept) begin
      op_q      <= btlpm_pkg::op_e'(opcode_i);
      addr_q    <= address_i;
      mask_q    <= prefix_mask_i;
      hop_in_q  <= route_next_hop_in_i;
      port_in_q <= route_port_in_i;
    end
  end

  assign busy_o     = (state_q != btlpm_pkg::S_IDLE);
  assign done_o     = done_q;
  assign found_o    = found_q;
  assign next_hop_o = hop_q;
  assign out_port_o = port_q;
  assign status_o   = status_q;

  // Node pool count never passes the pool size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= btlpm_pkg::UsedW'(btlpm_pkg::NodeCount))
    else $error("node pool count overflow");

  // Walk depth never passes the address width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= btlpm_pkg::LevelW'(btlpm_pkg::AddrBits))
    else $error("walk level overflow");

  // No read and write of the same node in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(node_we && node_re && (node_waddr == mem_raddr)))
    else $error("node memory read/write collision");

  // A result ends a walk that was running in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == btlpm_pkg::S_STEP))
    else $error("result without a walk");

  // Lookups never report a full pool; inserts never report a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(found_o && status_o))
    else $error("result mixes lookup and insert outcome");

endmodule

/* dv/binary_trie_longest_prefix_match_checker.sv */
`timescale 1ns / 100ps
// Route table scoreboard for binary_trie_longest_prefix_match: it mirrors the trie,
// predicts one answer per accepted request and checks each result against it.
// Depends on btlpm_pkg.
module binary_trie_longest_prefix_match_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic                           done_i,
  input  logic                           opcode_i,
  input  logic [btlpm_pkg::AddrBits-1:0] address_i,
  input  logic [btlpm_pkg::AddrBits-1:0] prefix_mask_i,
  input  logic [btlpm_pkg::AddrBits-1:0] route_next_hop_in_i,
  input  logic [btlpm_pkg::PortW-1:0]    route_port_in_i,
  input  logic                           found_i,
  input  logic [btlpm_pkg::AddrBits-1:0] next_hop_i,
  input  logic [btlpm_pkg::PortW-1:0]    out_port_i,
  input  logic                           status_i,
  output int unsigned                    error_count_o,
  output int unsigned                    pending_o
);

  typedef struct packed {
    logic                           found;
    logic [btlpm_pkg::AddrBits-1:0] hop;
    logic [btlpm_pkg::PortW-1:0]    out_port;
    btlpm_pkg::status_e             status;
  } route_answer_t;

  // Mirror of the node pool.
  logic [btlpm_pkg::NodeIdxW-1:0] left_of    [btlpm_pkg::NodeCount];
  logic [btlpm_pkg::NodeIdxW-1:0] right_of   [btlpm_pkg::NodeCount];
  logic                           route_here [btlpm_pkg::NodeCount];
  logic [btlpm_pkg::AddrBits-1:0] hop_at     [btlpm_pkg::NodeCount];
  logic [btlpm_pkg::PortW-1:0]    port_at    [btlpm_pkg::NodeCount];
  logic [btlpm_pkg::UsedW-1:0]    nodes_taken = btlpm_pkg::UsedW'(1);

  route_answer_t awaited_answers[$];
  route_answer_t oldest;
  int unsigned   errors = 0;
  int unsigned   pending = 0;

  assign error_count_o = errors;
  assign pending_o     = pending;

  function automatic route_answer_t answer_for(btlpm_pkg::op_e op,
                                               logic [btlpm_pkg::AddrBits-1:0] addr,
                                               logic [btlpm_pkg::AddrBits-1:0] mask,
                                               logic [btlpm_pkg::AddrBits-1:0] hop,
                                               logic [btlpm_pkg::PortW-1:0] port);
    route_answer_t                  ans;
    logic [btlpm_pkg::NodeIdxW-1:0] node;
    logic [btlpm_pkg::NodeIdxW-1:0] child;
    logic                           go_right;
    logic                           walking;
    ans = '0;
    ans.status = btlpm_pkg::STATUS_OK;
    node = '0;
    walking = 1'b1;
    if (op == btlpm_pkg::OP_INSERT) begin
      for (int lvl = 0; lvl < btlpm_pkg::AddrBits; lvl++) begin
        if (walking && mask[btlpm_pkg::AddrBits-1-lvl]) begin
          go_right = addr[btlpm_pkg::AddrBits-1-lvl];
          child = go_right ? right_of[node] : left_of[node];
          if (child == '0) begin
            if (nodes_taken >= btlpm_pkg::NodeCount) begin
              // pool exhausted: nodes taken so far stay, no route is stored
              walking = 1'b0;
              ans.status = btlpm_pkg::STATUS_FULL;
            end else begin
              child = nodes_taken[btlpm_pkg::NodeIdxW-1:0];
              nodes_taken = nodes_taken + 1'b1;
              left_of[child] = '0;
              right_of[child] = '0;
              route_here[child] = 1'b0;
              if (go_right) begin
                right_of[node] = child;
              end else begin
                left_of[node] = child;
              end
            end
          end
          if (walking) node = child;
        end
      end
      if (walking) begin
        route_here[node] = 1'b1;
        hop_at[node] = hop;
        port_at[node] = port;
      end
    end else begin
      // the full-depth node is visited too, so host routes match
      for (int depth = 0; depth <= btlpm_pkg::AddrBits; depth++) begin
        if (walking) begin
          if (route_here[node]) begin
            ans.found = 1'b1;
            ans.hop = hop_at[node];
            ans.out_port = port_at[node];
          end
          if (depth == btlpm_pkg::AddrBits) begin
            walking = 1'b0;
          end else begin
            child = addr[btlpm_pkg::AddrBits-1-depth] ? right_of[node] : left_of[node];
            if (child == '0) begin
              walking = 1'b0;
            end else begin
              node = child;
            end
          end
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_taken = btlpm_pkg::UsedW'(1);
      left_of[0] = '0;
      right_of[0] = '0;
      route_here[0] = 1'b0;
      awaited_answers.delete();
    end else begin
      // queue the new request first so a same-edge result still pops the oldest
      if (start_i && !busy_i) begin
        awaited_answers.push_back(answer_for(btlpm_pkg::op_e'(opcode_i), address_i,
                                             prefix_mask_i, route_next_hop_in_i,
                                             route_port_in_i));
      end
      if (done_i) begin
        if (awaited_answers.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          oldest = awaited_answers.pop_front();
          if (found_i !== oldest.found) begin
            $error("found: expected %0d, got %0d", oldest.found, found_i);
            errors++;
          end
          if (next_hop_i !== oldest.hop) begin
            $error("next_hop_o: expected %h, got %h", oldest.hop, next_hop_i);
            errors++;
          end
          if (out_port_i !== oldest.out_port) begin
            $error("out_port: expected %0d, got %0d", oldest.out_port, out_port_i);
            errors++;
          end
          if (status_i !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, status_i);
            errors++;
          end
        end
      end
    end
    pending = awaited_answers.size();
  end

endmodule

/* dv/binary_trie_longest_prefix_match_tb.sv */
`timescale 1ns / 100ps
// Top of the route table testbench: clock, reset, directed and random route requests,
// watchdog and verdict. Depends on btlpm_pkg, the block and its checker module.
module binary_trie_longest_prefix_match_tb;

  localparam int ResetCycles    = 10;
  localparam int RandomRequests = 1780;
  localparam int MaxGap         = 19;
  localparam int StretchLength  = 60;
  localparam int DrainCycles    = 40;
  localparam int WatchdogLimit  = 2000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           opcode = btlpm_pkg::OP_INSERT;
  logic [btlpm_pkg::AddrBits-1:0] address = '0;
  logic [btlpm_pkg::AddrBits-1:0] prefix_mask = '0;
  logic [btlpm_pkg::AddrBits-1:0] route_next_hop = '0;
  logic [btlpm_pkg::PortW-1:0]    route_port = '0;
  logic                           busy;
  logic                           done;
  logic                           found;
  logic [btlpm_pkg::AddrBits-1:0] result_hop;
  logic [btlpm_pkg::PortW-1:0]    out_port;
  logic                           status;
  int unsigned                    error_count;
  int unsigned                    pending_results;

  bit                             steady_feed = 1'b0;
  int                             idle_cycles = 0;

  // Prefixes already sent, folded to the trie path they take.
  logic [btlpm_pkg::AddrBits-1:0] route_keys[$];
  logic [btlpm_pkg::AddrBits-1:0] route_key_masks[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  binary_trie_longest_prefix_match dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start_i             (start),
    .busy_o              (busy),
    .done_o              (done),
    .opcode_i            (opcode),
    .address_i           (address),
    .prefix_mask_i       (prefix_mask),
    .route_next_hop_in_i (route_next_hop),
    .route_port_in_i     (route_port),
    .found_o             (found),
    .next_hop_o          (result_hop),
    .out_port_o          (out_port),
    .status_o            (status)
  );

  binary_trie_longest_prefix_match_checker route_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start_i             (start),
    .busy_i              (busy),
    .done_i              (done),
    .opcode_i            (opcode),
    .address_i           (address),
    .prefix_mask_i       (prefix_mask),
    .route_next_hop_in_i (route_next_hop),
    .route_port_in_i     (route_port),
    .found_i             (found),
    .next_hop_i          (result_hop),
    .out_port_i          (out_port),
    .status_i            (status),
    .error_count_o       (error_count),
    .pending_o           (pending_results)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("binary_trie_longest_prefix_match_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [btlpm_pkg::AddrBits-1:0] length_mask(int len);
    return (len == 0) ? '0 : ~{btlpm_pkg::AddrBits{1'b0}} << (btlpm_pkg::AddrBits - len);
  endfunction

  // Enter at a falling edge, leave at the falling edge after the request is taken.
  task automatic send_request(btlpm_pkg::op_e op, logic [btlpm_pkg::AddrBits-1:0] addr,
                              logic [btlpm_pkg::AddrBits-1:0] mask,
                              logic [btlpm_pkg::AddrBits-1:0] hop,
                              logic [btlpm_pkg::PortW-1:0] port);
    int gap;
    bit taken;
    gap = steady_feed ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode <= op;
    address <= addr;
    prefix_mask <= mask;
    route_next_hop <= hop;
    route_port <= port;
    start <= 1'b1;
    do begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic random_request();
    logic [btlpm_pkg::AddrBits-1:0] addr;
    logic [btlpm_pkg::AddrBits-1:0] mask;
    logic [btlpm_pkg::AddrBits-1:0] key;
    logic [btlpm_pkg::AddrBits-1:0] key_mask;
    int pick;
    int idx;
    int k;
    addr = $urandom;
    if (route_keys.size() > 0) begin
      idx = $urandom_range(0, route_keys.size() - 1);
    end else begin
      idx = -1;
    end
    if ($urandom_range(0, 19) < 11) begin
      // aim most lookups under a known prefix so deep matches get exercised
      if (idx >= 0 && $urandom_range(0, 9) < 8) begin
        addr = (route_keys[idx] & route_key_masks[idx]) | ($urandom & ~route_key_masks[idx]);
      end
      send_request(btlpm_pkg::OP_LOOKUP, addr, $urandom, $urandom,
                   btlpm_pkg::PortW'($urandom_range(0, 15)));
    end else begin
      if (idx >= 0 && $urandom_range(0, 9) < 4) begin
        addr = (route_keys[idx] & route_key_masks[idx]) | ($urandom & ~route_key_masks[idx]);
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        mask = length_mask($urandom_range(24, 32));
      end else if (pick < 6) begin
        mask = length_mask($urandom_range(8, 23));
      end else if (pick < 7) begin
        mask = length_mask($urandom_range(0, 7));
      end else if (pick < 9 || idx < 0) begin
        mask = $urandom;
      end else begin
        // insert again on the trie path of a prefix already sent
        addr = route_keys[idx];
        mask = route_key_masks[idx];
      end
      key = '0;
      key_mask = '0;
      k = btlpm_pkg::AddrBits - 1;
      for (int b = btlpm_pkg::AddrBits - 1; b >= 0; b--) begin
        if (mask[b]) begin
          key[k] = addr[b];
          key_mask[k] = 1'b1;
          k--;
        end
      end
      route_keys.push_back(key);
      route_key_masks.push_back(key_mask);
      send_request(btlpm_pkg::OP_INSERT, addr, mask, $urandom,
                   btlpm_pkg::PortW'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // empty table, both address extremes
    send_request(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    send_request(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 4'h0);
    // default route; prefix bits under a clear mask are ignored
    send_request(btlpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF);
    send_request(btlpm_pkg::OP_LOOKUP, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 4'h0);
    // host routes at both ends
    send_request(btlpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0);
    send_request(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(btlpm_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 4'h5);
    send_request(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(btlpm_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 4'h0);
    // nested prefixes, longest one wins
    send_request(btlpm_pkg::OP_INSERT, 32'h0A00_0000, 32'hFF00_0000, 32'h0A0A_0A01, 4'h1);
    send_request(btlpm_pkg::OP_LOOKUP, 32'h0A01_0203, 32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(btlpm_pkg::OP_INSERT, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 4'h2);
    send_request(btlpm_pkg::OP_LOOKUP, 32'h0A01_0203, 32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(btlpm_pkg::OP_LOOKUP, 32'h0A02_0304, 32'h0000_0000, 32'h0000_0000, 4'h0);
    // same /8 again with junk host bits: overwrite
    send_request(btlpm_pkg::OP_INSERT, 32'h0AFF_FFFF, 32'hFF00_0000, 32'h5A5A_5A5A, 4'hA);
    send_request(btlpm_pkg::OP_LOOKUP, 32'h0A7F_0000, 32'h0000_0000, 32'h0000_0000, 4'h0);
    // gapped mask: the trie path is the selected bits packed to the top
    send_request(btlpm_pkg::OP_INSERT, 32'hC0A8_0101, 32'hF0F0_F0F0, 32'hC0A8_01FE, 4'hC);
    send_request(btlpm_pkg::OP_LOOKUP, 32'hCA00_1234, 32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(btlpm_pkg::OP_LOOKUP, 32'hC0A8_0101, 32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(btlpm_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 4'h8);
    send_request(btlpm_pkg::OP_LOOKUP, 32'h9000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0);

    // long prefixes dominate, so the node pool runs dry partway through
    for (int n = 0; n < RandomRequests; n++) begin
      if (n % StretchLength == 0) steady_feed = ($urandom_range(0, 3) == 0);
      random_request();
    end
    start <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("binary_trie_longest_prefix_match_tb: done, clean");
    end else begin
      $display("binary_trie_longest_prefix_match_tb: done, errors");
    end
    $finish;
  end

endmodule
